// ===== hdl/swmv_pkg.sv =====
// ----------------------------------------------------------------------------
// swmv_pkg: shared types and constants of the sliding window mean/variance
// Field widths, the job carried from the front to the back, and state codes.
// ----------------------------------------------------------------------------
package swmv_pkg;

	localparam int STAMP_BITS = 64;
	localparam int SUM_BITS   = 32;
	localparam int SQ_BITS    = 56;
	localparam int MEAN_BITS  = 24;
	localparam int VAR_BITS   = 48;
	localparam int REG_BITS   = 9;

	localparam logic [REG_BITS-1:0] WL_RESET = 9'd16;

	// Radix-4 division retires two quotient bits per step.
	localparam int SUM_STEPS = SUM_BITS / 2;
	localparam int SQ_STEPS  = SQ_BITS / 2;
	localparam int STEP_BITS = $clog2(SQ_STEPS);

	localparam int OUT_BITS       = STAMP_BITS + MEAN_BITS + VAR_BITS;
	localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic [STAMP_BITS-1:0] stamp;
		logic [SUM_BITS-1:0]   sum;
		logic [SQ_BITS-1:0]    sumsq;
		logic [REG_BITS-1:0]   n;
	} job_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SQUARE,
		F_COMMIT
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_DIV_SUM,
		B_DIV_SQ,
		B_SQUARE,
		B_FINISH
	} back_state_t;

endpackage

// ===== hdl/swmv_front.sv =====
// ----------------------------------------------------------------------------
// swmv_front: tick intake and window bookkeeping
// Keeps the price ring, pointer, fill count and both running sums, and hands
// a job to the queue for every tick that completes a window.
// ----------------------------------------------------------------------------
module swmv_front #(
	parameter int WINDOW_DEPTH = 256,
	parameter int PRICE_BITS   = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [swmv_pkg::REG_BITS-1:0]     cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [swmv_pkg::STAMP_BITS-1:0]   in_stamp,
	input  logic [PRICE_BITS-1:0]             in_price,
	output logic                              job_valid,
	input  logic                              job_ready,
	output swmv_pkg::job_t                    job
);
	import swmv_pkg::*;

	localparam int PTR_BITS   = $clog2(WINDOW_DEPTH);
	localparam int DEPTH_BITS = $clog2(WINDOW_DEPTH + 1);
	localparam int CMP_BITS   = (DEPTH_BITS > REG_BITS) ? DEPTH_BITS : REG_BITS;
	localparam int SQR_BITS   = 2 * PRICE_BITS;

	front_state_t state_q, state_d;

	logic [REG_BITS-1:0]   wl_q;
	logic [PTR_BITS-1:0]   ptr_q, ptr_d;
	logic [REG_BITS-1:0]   fill_q, fill_d;
	logic [SUM_BITS-1:0]   sum_q, sum_d;
	logic [SQ_BITS-1:0]    sumsq_q, sumsq_d;
	logic [STAMP_BITS-1:0] stamp_q;
	logic [PRICE_BITS-1:0] price_q, old_q;
	logic [SQR_BITS-1:0]   sq_new_s2, sq_old_s2;
	logic [PRICE_BITS-1:0] ring_mem [WINDOW_DEPTH];

	logic [REG_BITS-1:0] n;
	logic                full, produce, wrap, accept, commit;

	// A length of zero acts as one, and one above the depth acts as the depth.
	always_comb begin
		if (wl_q == '0) begin
			n = REG_BITS'(1);
		end else if (CMP_BITS'(wl_q) > CMP_BITS'(WINDOW_DEPTH)) begin
			n = REG_BITS'(WINDOW_DEPTH);
		end else begin
			n = wl_q;
		end
	end

	assign full    = (fill_q >= n);
	assign fill_d  = full ? fill_q : fill_q + REG_BITS'(1);
	assign produce = (fill_d >= n);
	assign sum_d   = sum_q - (full ? SUM_BITS'(old_q) : '0) + SUM_BITS'(price_q);
	assign sumsq_d = sumsq_q - (full ? SQ_BITS'(sq_old_s2) : '0) + SQ_BITS'(sq_new_s2);
	assign wrap    = (CMP_BITS'(ptr_q) + CMP_BITS'(1)) >= CMP_BITS'(n);
	assign ptr_d   = wrap ? '0 : ptr_q + PTR_BITS'(1);

	assign accept = in_valid && in_ready;

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		job_valid = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = F_SQUARE;
				end
			end
			F_SQUARE: begin
				state_d = F_COMMIT;
			end
			F_COMMIT: begin
				job_valid = produce;
				if (!produce || job_ready) begin
					commit  = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	assign job.stamp = stamp_q;
	assign job.sum   = sum_d;
	assign job.sumsq = sumsq_d;
	assign job.n     = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			wl_q    <= WL_RESET;
			ptr_q   <= '0;
			fill_q  <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				wl_q    <= cfg_data;
				ptr_q   <= '0;
				fill_q  <= '0;
				sum_q   <= '0;
				sumsq_q <= '0;
			end else if (commit) begin
				ptr_q   <= ptr_d;
				fill_q  <= fill_d;
				sum_q   <= sum_d;
				sumsq_q <= sumsq_d;
			end
		end
	end

	// The oldest price is read as the item arrives; the slot is rewritten in the
	// square state, once the old value is safely held.
	always_ff @(posedge clk) begin
		if (accept) begin
			stamp_q <= in_stamp;
			price_q <= in_price;
			old_q   <= ring_mem[ptr_q];
		end
		if (state_q == F_SQUARE) begin
			sq_new_s2        <= SQR_BITS'(price_q) * SQR_BITS'(price_q);
			sq_old_s2        <= SQR_BITS'(old_q) * SQR_BITS'(old_q);
			ring_mem[ptr_q]  <= price_q;
		end
	end

endmodule

// ===== hdl/swmv_queue.sv =====
// ----------------------------------------------------------------------------
// swmv_queue: two-entry job queue
// Decouples window bookkeeping from the divider so each side stalls alone.
// ----------------------------------------------------------------------------
module swmv_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  swmv_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output swmv_pkg::job_t pop_job
);
	import swmv_pkg::*;

	localparam int DEPTH = 2;

	job_t       entry_q [DEPTH];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign push_ready = (cnt_q != 2'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_job    = entry_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_job;
		end
	end

endmodule

// ===== hdl/swmv_back.sv =====
// ----------------------------------------------------------------------------
// swmv_back: mean and variance engine
// A shared radix-4 divider forms sum/N and sumsq/N, then the variance is
// formed and parked in the output register.
// ----------------------------------------------------------------------------
module swmv_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                job_valid,
	output logic                                job_ready,
	input  swmv_pkg::job_t                      job,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [swmv_pkg::OUT_TDATA_BITS-1:0] out_data
);
	import swmv_pkg::*;

	localparam int PROD_BITS = 2 * SUM_BITS;

	back_state_t state_q, state_d;

	logic [STEP_BITS-1:0]  cnt_q;
	logic [SQ_BITS-1:0]    div_q, div_nx;
	logic [REG_BITS-1:0]   rem_q, rem_nx;
	logic [REG_BITS+1:0]   n_q, n2_q, n3_q, r4;
	logic [1:0]            digit;
	logic [STAMP_BITS-1:0] stamp_q;
	logic [SQ_BITS-1:0]    sumsq_q, msq_q;
	logic [SUM_BITS-1:0]   mean_q;
	logic [PROD_BITS-1:0]  m2_q, msq_ext, var_full;
	logic                  out_valid_q;
	logic [OUT_TDATA_BITS-1:0] out_data_q;
	logic                  last_sum, last_sq, emit, take;

	// One radix-4 digit: compare the shifted partial remainder with N, 2N, 3N.
	assign r4 = {rem_q, div_q[SQ_BITS-1 -: 2]};
	always_comb begin
		if (r4 >= n3_q) begin
			digit  = 2'd3;
			rem_nx = REG_BITS'(r4 - n3_q);
		end else if (r4 >= n2_q) begin
			digit  = 2'd2;
			rem_nx = REG_BITS'(r4 - n2_q);
		end else if (r4 >= n_q) begin
			digit  = 2'd1;
			rem_nx = REG_BITS'(r4 - n_q);
		end else begin
			digit  = 2'd0;
			rem_nx = REG_BITS'(r4);
		end
	end
	assign div_nx = {div_q[SQ_BITS-3:0], digit};

	assign last_sum = (cnt_q == STEP_BITS'(SUM_STEPS - 1));
	assign last_sq  = (cnt_q == STEP_BITS'(SQ_STEPS - 1));

	assign msq_ext  = PROD_BITS'(msq_q);
	assign var_full = (msq_ext >= m2_q) ? msq_ext - m2_q : '0;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		emit      = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					state_d = B_DIV_SUM;
				end
			end
			B_DIV_SUM: begin
				if (last_sum) begin
					state_d = B_DIV_SQ;
				end
			end
			B_DIV_SQ: begin
				if (last_sq) begin
					state_d = B_SQUARE;
				end
			end
			B_SQUARE: begin
				state_d = B_FINISH;
			end
			B_FINISH: begin
				if (!out_valid_q || out_ready) begin
					emit    = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	assign take = job_valid && job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take || (state_q == B_DIV_SUM && last_sum) || state_q == B_SQUARE) begin
				cnt_q <= '0;
			end else if (state_q == B_DIV_SUM || state_q == B_DIV_SQ) begin
				cnt_q <= cnt_q + STEP_BITS'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			// The sum sits in the top bits so its quotient lands in the low bits.
			div_q   <= {job.sum, {(SQ_BITS - SUM_BITS){1'b0}}};
			rem_q   <= '0;
			n_q     <= (REG_BITS+2)'(job.n);
			n2_q    <= (REG_BITS+2)'({job.n, 1'b0});
			n3_q    <= (REG_BITS+2)'(job.n) + (REG_BITS+2)'({job.n, 1'b0});
			stamp_q <= job.stamp;
			sumsq_q <= job.sumsq;
		end
		if (state_q == B_DIV_SUM) begin
			if (last_sum) begin
				mean_q <= div_nx[SUM_BITS-1:0];
				div_q  <= sumsq_q;
				rem_q  <= '0;
			end else begin
				div_q <= div_nx;
				rem_q <= rem_nx;
			end
		end
		if (state_q == B_DIV_SQ) begin
			div_q <= div_nx;
			rem_q <= rem_nx;
			if (last_sq) begin
				msq_q <= div_nx;
			end
		end
		if (state_q == B_SQUARE) begin
			m2_q <= PROD_BITS'(mean_q) * PROD_BITS'(mean_q);
		end
		if (emit) begin
			out_data_q <= OUT_TDATA_BITS'({var_full[VAR_BITS-1:0], mean_q[MEAN_BITS-1:0],
				stamp_q});
		end
	end

endmodule

// ===== hdl/sliding_window_mean_variance.sv =====
// ----------------------------------------------------------------------------
// sliding_window_mean_variance: rolling mean and variance of price ticks
// Top level: tick intake, job queue and divider engine.
// ----------------------------------------------------------------------------
// Each accepted tick moves through the idle, square and commit states of the
// intake, which updates the price ring and the running sums. The first N-1
// ticks after reset or after a write of window_length only fill the window.
// Every later tick gives one result, and the radix-4 divider that forms both
// sum/N and sumsq/N sets the pace: a result-giving tick occupies it for 16
// digit steps for the mean, 28 for the mean of squares, plus load, square and
// output. A two-entry queue and the output register let intake and divider
// stall independently. Write window_length only while the block is idle; a
// write restarts the window.
module sliding_window_mean_variance #(
	parameter int WINDOW_DEPTH = 256,
	parameter int PRICE_BITS   = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [swmv_pkg::REG_BITS-1:0] cfg_data,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// timestamp [63:0], price [PRICE_BITS+63:64], zero padding above
	input  logic [((swmv_pkg::STAMP_BITS + PRICE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// stamp_out [63:0], mean [87:64], variance [135:88]
	output logic [swmv_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);
	import swmv_pkg::*;

	logic job_valid_f, job_ready_f;
	job_t job_f;
	logic job_valid_b, job_ready_b;
	job_t job_b;

	swmv_front #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.PRICE_BITS  (PRICE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_stamp (s_axis_tdata[STAMP_BITS-1:0]),
		.in_price (s_axis_tdata[STAMP_BITS +: PRICE_BITS]),
		.job_valid(job_valid_f),
		.job_ready(job_ready_f),
		.job      (job_f)
	);

	swmv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(job_valid_f),
		.push_ready(job_ready_f),
		.push_job  (job_f),
		.pop_valid (job_valid_b),
		.pop_ready (job_ready_b),
		.pop_job   (job_b)
	);

	swmv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid_b),
		.job_ready(job_ready_b),
		.job      (job_b),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata)
	);

	// The intake is busy for the cycle after it takes an item.
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("intake accepted two items in consecutive cycles");

	// A job refused by a full queue is held unchanged by the intake.
	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_f && !job_ready_f |=> job_valid_f && $stable(job_f))
		else $error("intake dropped or changed a stalled job");

	// The divider engine takes one job at a time.
	a_back_busy: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_b && job_ready_b |=> !job_ready_b)
		else $error("divider engine took a job while busy");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for sliding_window_mean_variance
// Streams timestamped price ticks through the block under several window
// lengths, predicts each rolling mean and variance in a local window model,
// and compares every result item field by field against the oldest
// prediction. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;

	import swmv_pkg::*;

	localparam int PRICE_W      = 24;
	localparam int DEPTH        = 256;
	localparam int IN_TDATA_W   = ((STAMP_BITS + PRICE_W + 7) / 8) * 8;
	localparam int TICK_TARGET  = 1850;
	localparam int DRAIN_CYCLES = 64;
	localparam int QUIET_LIMIT  = 4000;

	// Members run from the highest bits down, so the stamp lands lowest.
	typedef struct packed {
		logic [VAR_BITS-1:0]   variance;
		logic [MEAN_BITS-1:0]  mean;
		logic [STAMP_BITS-1:0] stamp;
	} tick_stats_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [REG_BITS-1:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

	// Local copy of the window state.
	logic [PRICE_W-1:0]  price_hist [DEPTH];
	logic [7:0]          slot_ptr;
	logic [REG_BITS-1:0] held;
	logic [SUM_BITS-1:0] price_sum;
	logic [SQ_BITS-1:0]  square_sum;
	logic [REG_BITS-1:0] window_reg;

	tick_stats_t pending_stats[$];
	int mismatches;
	int ticks_sent;
	int quiet_cycles;
	int stall_left;
	bit calm;
	logic [STAMP_BITS-1:0] stamp_clock;

	sliding_window_mean_variance dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void restart_window_model();
		slot_ptr   = '0;
		held       = '0;
		price_sum  = '0;
		square_sum = '0;
	endfunction

	// Applies one tick to the window model; returns 1 when the tick completes
	// a window and fills in the statistics it should produce.
	function automatic bit update_window_stats(input logic [STAMP_BITS-1:0] ts,
			input logic [PRICE_W-1:0] pr, output tick_stats_t res);
		logic [REG_BITS-1:0] n;
		logic [SQ_BITS-1:0]  old_wide;
		logic [SQ_BITS-1:0]  new_wide;
		logic [63:0]         mean_full;
		logic [63:0]         mean_sq;
		logic [63:0]         sq_mean;
		logic [63:0]         spread;
		n = window_reg;
		if (n == '0) n = REG_BITS'(1);
		if (n > DEPTH) n = REG_BITS'(DEPTH);
		res = '0;
		if (held >= n) begin
			old_wide   = SQ_BITS'(price_hist[slot_ptr]);
			price_sum  = price_sum - SUM_BITS'(price_hist[slot_ptr]);
			square_sum = square_sum - old_wide * old_wide;
		end else begin
			held = held + REG_BITS'(1);
		end
		new_wide   = SQ_BITS'(pr);
		price_hist[slot_ptr] = pr;
		price_sum  = price_sum + SUM_BITS'(pr);
		square_sum = square_sum + new_wide * new_wide;
		if ({1'b0, slot_ptr} + 9'd1 >= n)
			slot_ptr = '0;
		else
			slot_ptr = slot_ptr + 8'd1;
		if (held < n)
			return 1'b0;
		mean_full = 64'(price_sum) / 64'(n);
		sq_mean   = 64'(square_sum) / 64'(n);
		mean_sq   = mean_full * mean_full;
		spread    = (sq_mean >= mean_sq) ? sq_mean - mean_sq : 64'd0;
		res.stamp    = ts;
		res.mean     = mean_full[MEAN_BITS-1:0];
		res.variance = spread[VAR_BITS-1:0];
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	function automatic logic [PRICE_W-1:0] pick_price();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return PRICE_W'($urandom_range(0, 255));
			3: return {PRICE_W{1'b1}} - PRICE_W'($urandom_range(0, 255));
			default: return PRICE_W'($urandom);
		endcase
	endfunction

	function automatic logic [STAMP_BITS-1:0] pick_stamp();
		if ($urandom_range(0, 15) == 0)
			return {$urandom, $urandom};
		stamp_clock = stamp_clock + $urandom_range(1, 1000);
		return stamp_clock;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("ERROR %0t: %s got %h, expected %h", $time, field, got, want);
		mismatches++;
	endtask

	// Sends one tick and waits until it is accepted. Valid stays high on
	// return, so back-to-back items are sent without dropping valid between them.
	task automatic send_tick(input logic [STAMP_BITS-1:0] ts, input logic [PRICE_W-1:0] pr);
		int gap;
		tick_stats_t res;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_TDATA_W'({pr, ts});
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		ticks_sent++;
		if (update_window_stats(ts, pr, res))
			pending_stats.push_back(res);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_stats.size() != 0) @(posedge clk);
		// Ticks that give no result may still be in the intake.
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [REG_BITS-1:0] value);
		wait_drained();
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		window_reg = value;
		restart_window_model();
	endtask

	task automatic test_default_window();
		int i;
		logic [PRICE_W-1:0] pr;
		logic [STAMP_BITS-1:0] ts;
		// Alternate the extremes to fill the reset-length window, then keep
		// pushing full-scale prices so the oldest entries roll out.
		for (i = 0; i < 20; i++) begin
			pr = (i >= 16 || i % 2 == 1) ? {PRICE_W{1'b1}} : '0;
			ts = (i % 2 == 0) ? ~64'(i) : 64'(i);
			send_tick(ts, pr);
		end
	endtask

	task automatic test_unit_window();
		write_window(9'd1);
		send_tick('1, '1);
		send_tick('0, '0);
		send_tick(64'h0123_4567_89ab_cdef, 24'h5a5a5a);
		// A zero length behaves as a window of one.
		write_window(9'd0);
		send_tick(64'h8000_0000_0000_0001, 24'h800001);
		send_tick(64'h7fff_ffff_ffff_fffe, 24'h7ffffe);
	endtask

	task automatic test_deep_window();
		int i;
		// Oversized length clamps to full depth; mostly full-scale prices push
		// both accumulators toward their largest values.
		write_window(9'd511);
		for (i = 0; i < 262; i++)
			send_tick(pick_stamp(), (i % 50 == 49) ? pick_price() : {PRICE_W{1'b1}});
		write_window(9'd300);
		for (i = 0; i < 290; i++)
			send_tick(pick_stamp(), pick_price());
	endtask

	task automatic test_random_windows();
		int i;
		int count;
		logic [REG_BITS-1:0] wl;
		while (ticks_sent < TICK_TARGET) begin
			case ($urandom_range(0, 19))
				0:       wl = '0;
				1, 2:    wl = 9'd2;
				3, 4:    wl = REG_BITS'($urandom_range(25, 64));
				default: wl = REG_BITS'($urandom_range(1, 24));
			endcase
			calm = ($urandom_range(0, 3) == 0);
			write_window(wl);
			count = $urandom_range(int'(wl) + 10, int'(wl) + 90);
			for (i = 0; i < count; i++)
				send_tick(pick_stamp(), pick_price());
		end
		calm = 1'b0;
	endtask

	task automatic finish_run();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	endtask

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_data      <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		mismatches  = 0;
		ticks_sent  = 0;
		calm        = 1'b0;
		stamp_clock = '0;
		window_reg  = WL_RESET;
		restart_window_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_window();
		test_unit_window();
		test_deep_window();
		test_random_windows();
		finish_run();
	end

	// Result sink with random stalls.
	initial begin
		m_axis_tready <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		tick_stats_t want;
		tick_stats_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[STAMP_BITS+MEAN_BITS+VAR_BITS-1:0];
			if (pending_stats.size() == 0) begin
				report_mismatch("unexpected result, stamp_out", got.stamp, '0);
			end else begin
				want = pending_stats.pop_front();
				if (got.stamp !== want.stamp)
					report_mismatch("stamp_out", got.stamp, want.stamp);
				if (got.mean !== want.mean)
					report_mismatch("mean", 64'(got.mean), 64'(want.mean));
				if (got.variance !== want.variance)
					report_mismatch("variance", 64'(got.variance), 64'(want.variance));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_axis_tvalid && s_axis_tready)
				|| (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TIMEOUT %0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

// ===== sim.f =====
hdl/swmv_pkg.sv
hdl/swmv_front.sv
hdl/swmv_queue.sv
hdl/swmv_back.sv
hdl/sliding_window_mean_variance.sv
tb/tb.sv
